// ===== hw/rtl/mipmap_box_pyramid_defines.svh =====
// ----------------------------------------------------------------------------
// mipmap_box_pyramid_defines.svh
// Assertion macros shared by the mip pyramid RTL.
// ----------------------------------------------------------------------------
`ifndef MIPMAP_BOX_PYRAMID_DEFINES_SVH
`define MIPMAP_BOX_PYRAMID_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked assertion, masked while reset is high
`define MBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion, checked at every edge
`define MBP_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBP_ASSERT(label, clk, rst, prop, msg)
`define MBP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbp_pkg
// Types, widths and register codes of the mip pyramid generator.
// ----------------------------------------------------------------------------
package mbp_pkg;

   // Default sizing of the line buffer and level count
   localparam int unsigned MAX_LOG2_SIZE_DEF = 10;
   localparam int unsigned MAX_LEVELS_DEF    = 11;

   // Field widths
   localparam int unsigned PIXEL_W  = 32;
   localparam int unsigned LANES    = 4;
   localparam int unsigned LANE_W   = 8;
   localparam int unsigned SUM_W    = 9;
   localparam int unsigned PAIR_W   = LANES * SUM_W;
   localparam int unsigned MLEVEL_W = 4;
   localparam int unsigned COL_W    = 14;
   localparam int unsigned ROW_W    = 14;
   localparam int unsigned LOG2_W   = 4;
   localparam int unsigned LEVEL_W  = 5;

   // Configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 5;

   typedef logic [PIXEL_W-1:0]  pixel_type;
   typedef logic [PAIR_W-1:0]   pair_type;
   typedef logic [MLEVEL_W-1:0] mlevel_type;
   typedef logic [COL_W-1:0]    col_type;
   typedef logic [ROW_W-1:0]    row_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT = 2'd2;

endpackage

// ===== hw/rtl/mbp_req_if.sv =====
// ----------------------------------------------------------------------------
// mbp_req_if
// Input channel: one base pixel per transfer.
// ----------------------------------------------------------------------------
interface mbp_req_if;
   import mbp_pkg::*;

   logic      valid;
   logic      ready;
   pixel_type base_pixel;

   modport source (output valid, output base_pixel, input ready);
   modport sink   (input valid, input base_pixel, output ready);
endinterface

// ===== hw/rtl/mbp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mbp_rsp_if
// Result channel: one tagged mip pixel per transfer.
// ----------------------------------------------------------------------------
interface mbp_rsp_if;
   import mbp_pkg::*;

   logic       valid;
   logic       ready;
   pixel_type  mip_pixel;
   mlevel_type mip_level;
   col_type    col;
   row_type    row;
   logic       last_of_run;

   modport source (output valid, output mip_pixel, output mip_level, output col,
                   output row, output last_of_run, input ready);
   modport sink   (input valid, input mip_pixel, input mip_level, input col,
                   input row, input last_of_run, output ready);
endinterface

// ===== hw/rtl/mbp_line_buf.sv =====
// ----------------------------------------------------------------------------
// mbp_line_buf
// Line buffer of even-row pair sums, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbp_line_buf #(
   parameter int unsigned ADDR_W = 10,
   parameter int unsigned DATA_W = 36
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   localparam int unsigned DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Store a pair sum
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/mbp_box_alu.sv =====
// ----------------------------------------------------------------------------
// mbp_box_alu
// Shared box filter arithmetic: horizontal pair sums and 2x2 averages.
// ----------------------------------------------------------------------------
module mbp_box_alu (
   input  mbp_pkg::pixel_type left_pixel,
   input  mbp_pkg::pixel_type right_pixel,
   input  mbp_pkg::pair_type  upper_pair,
   input  mbp_pkg::pair_type  lower_pair,
   output mbp_pkg::pair_type  pair_sum,
   output mbp_pkg::pixel_type quad_avg
);
   import mbp_pkg::*;

   // Add lane by lane into 9-bit sums
   always_comb begin
      pair_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         pair_sum[i*SUM_W +: SUM_W] = {1'b0, left_pixel[i*LANE_W +: LANE_W]}
                                    + {1'b0, right_pixel[i*LANE_W +: LANE_W]};
      end
   end

   // Combine two pair sums and drop the two low bits of each lane
   always_comb begin
      logic [SUM_W:0] s;
      quad_avg = '0;
      for (int i = 0; i < LANES; i++) begin
         s = {1'b0, upper_pair[i*SUM_W +: SUM_W]} + {1'b0, lower_pair[i*SUM_W +: SUM_W]};
         quad_avg[i*LANE_W +: LANE_W] = s[SUM_W:2];
      end
   end
endmodule

// ===== hw/rtl/mipmap_box_pyramid.sv =====
// An accepted pixel passes through the accept state and a first level step, and each
// result it causes adds a line buffer read and an average; a result is presented in
// the output register at the step that follows its average, and that step waits while
// the output register stays blocked. The level step sequencer accepts a new pixel only
// once it is back in idle, after the last result of the previous pixel is presented.
// Reset: synchronous, active high; clears the sequencer, configuration, level counters
// and output valid, data keeps its contents.
`include "mipmap_box_pyramid_defines.svh"
// ----------------------------------------------------------------------------
// mipmap_box_pyramid
// Streaming 2x2 box filter mip pyramid generator, one level step at a time.
// ----------------------------------------------------------------------------
module mipmap_box_pyramid #(
   parameter int unsigned MAX_LOG2_SIZE = mbp_pkg::MAX_LOG2_SIZE_DEF,
   parameter int unsigned MAX_LEVELS    = mbp_pkg::MAX_LEVELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   mbp_req_if.sink                          req,
   mbp_rsp_if.source                        rsp,
   input  logic                             csr_wr_en,
   input  logic [mbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mbp_pkg::*;

   localparam int unsigned CW  = MAX_LOG2_SIZE;
   localparam int unsigned AW  = MAX_LOG2_SIZE;
   localparam int unsigned LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   typedef enum logic [1:0] {S_IDLE, S_STEP, S_AVG} state_type;

   // Configuration registers
   logic [LOG2_W-1:0]  log2_width_ff;
   logic [LOG2_W-1:0]  log2_height_ff;
   logic [LEVEL_W-1:0] level_count_ff;
   logic               cfg_clear;

   // Sequencer and datapath registers
   state_type          state_ff;
   logic [LVW-1:0]     n_ff;
   pixel_type          px_ff;
   pair_type           pair_ff;
   logic               pend_ff;
   col_type            pcol_ff;
   row_type            prow_ff;

   // Output register
   logic               rsp_valid_ff;
   pixel_type          rsp_pixel_ff;
   mlevel_type         rsp_level_ff;
   col_type            rsp_col_ff;
   row_type            rsp_row_ff;
   logic               rsp_last_ff;

   // Per-level position counters and held even-column pixels
   logic [CW-1:0]      col_cnt_ff [MAX_LEVELS];
   logic [CW-1:0]      row_cnt_ff [MAX_LEVELS];
   pixel_type          hold_ff    [MAX_LEVELS];

   // Effective sizes
   logic [LOG2_W-1:0]  lw_eff;
   logic [LOG2_W-1:0]  lh_eff;
   logic [LEVEL_W-1:0] levels;

   // Level step signals
   logic [CW-1:0]      x;
   logic [CW-1:0]      y;
   logic [CW:0]        wn;
   logic [CW:0]        hn;
   logic [CW:0]        base_w;
   logic [CW:0]        idx_full;
   logic [AW-1:0]      idx;
   logic               x_last;
   logic               y_last;
   logic               active;
   logic               produce;
   logic               slot_free;
   logic               step_go;
   logic               emit;
   logic               lvl_act;
   logic               hold_we;
   logic               mem_we;
   logic               mem_re;
   pair_type           pair_sum;
   pixel_type          quad_avg;
   pair_type           upper_pair;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         log2_width_ff  <= '0;
         log2_height_ff <= '0;
         level_count_ff <= LEVEL_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LOG2_WIDTH:  log2_width_ff  <= csr_wdata[LOG2_W-1:0];
            CSR_LOG2_HEIGHT: log2_height_ff <= csr_wdata[LOG2_W-1:0];
            CSR_LEVEL_COUNT: level_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Flag writes that hit a register, those restart the frame
   always_comb begin
      case (csr_index)
         CSR_LOG2_WIDTH, CSR_LOG2_HEIGHT, CSR_LEVEL_COUNT: cfg_clear = csr_wr_en;
         default:                                         cfg_clear = 1'b0;
      endcase
   end

   // Saturate sizes and cap the level count
   always_comb begin
      logic [LOG2_W-1:0]  lmin;
      logic [LEVEL_W-1:0] cap;
      lw_eff = (log2_width_ff > LOG2_W'(MAX_LOG2_SIZE)) ? LOG2_W'(MAX_LOG2_SIZE)
                                                        : log2_width_ff;
      lh_eff = (log2_height_ff > LOG2_W'(MAX_LOG2_SIZE)) ? LOG2_W'(MAX_LOG2_SIZE)
                                                         : log2_height_ff;
      lmin   = (lw_eff < lh_eff) ? lw_eff : lh_eff;
      cap    = {1'b0, lmin} + LEVEL_W'(1);
      levels = (level_count_ff == '0) ? LEVEL_W'(1) : level_count_ff;
      if (levels > LEVEL_W'(MAX_LEVELS)) begin
         levels = LEVEL_W'(MAX_LEVELS);
      end
      if (levels > cap) begin
         levels = cap;
      end
   end

   // Decode the current level step
   assign x        = col_cnt_ff[n_ff];
   assign y        = row_cnt_ff[n_ff];
   assign wn       = (CW+1)'(1) << (lw_eff - LOG2_W'(n_ff));
   assign hn       = (CW+1)'(1) << (lh_eff - LOG2_W'(n_ff));
   assign x_last   = ({1'b0, x} + (CW+1)'(1)) >= wn;
   assign y_last   = ({1'b0, y} + (CW+1)'(1)) >= hn;
   assign base_w   = (CW+1)'(1) << lw_eff;
   assign idx_full = base_w - (base_w >> n_ff) + (CW+1)'(x >> 1);
   assign idx      = idx_full[AW-1:0];

   assign active    = (LEVEL_W'(n_ff) + LEVEL_W'(1)) < levels;
   assign produce   = active & x[0] & y[0];
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign step_go   = (state_ff == S_STEP) && (!pend_ff || slot_free);
   assign emit      = step_go && pend_ff;
   assign lvl_act   = step_go && active;
   assign hold_we   = lvl_act && !x[0];
   assign mem_we    = lvl_act && x[0] && !y[0];
   assign mem_re    = lvl_act && x[0] && y[0];

   // Shared box filter arithmetic
   mbp_box_alu u_alu (
      .left_pixel  (hold_ff[n_ff]),
      .right_pixel (px_ff),
      .upper_pair  (upper_pair),
      .lower_pair  (pair_ff),
      .pair_sum    (pair_sum),
      .quad_avg    (quad_avg)
   );

   // Line buffer of even-row pair sums
   mbp_line_buf #(
      .ADDR_W (AW),
      .DATA_W (PAIR_W)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (idx),
      .wr_data (pair_sum),
      .rd_en   (mem_re),
      .rd_addr (idx),
      .rd_data (upper_pair)
   );

   // Advance position counters, clear them on reset or a register write
   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_cnt_ff[i] <= '0;
            row_cnt_ff[i] <= '0;
         end
      end else if (lvl_act) begin
         if (x_last) begin
            col_cnt_ff[n_ff] <= '0;
            row_cnt_ff[n_ff] <= y_last ? '0 : y + CW'(1);
         end else begin
            col_cnt_ff[n_ff] <= x + CW'(1);
         end
      end
   end

   // Hold the even-column pixel of the level
   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_ff[n_ff] <= px_ff;
      end
   end

   // Sequence level steps and drive the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  px_ff    <= req.base_pixel;
                  n_ff     <= '0;
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               if (step_go) begin
                  pend_ff <= 1'b0;
                  if (produce) begin
                     pair_ff  <= pair_sum;
                     pcol_ff  <= COL_W'(x >> 1);
                     prow_ff  <= ROW_W'(y >> 1);
                     state_ff <= S_AVG;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_AVG: begin
               px_ff    <= quad_avg;
               pend_ff  <= 1'b1;
               n_ff     <= n_ff + LVW'(1);
               state_ff <= S_STEP;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // Present the pending result, tag it last when the cascade stops here
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_pixel_ff <= px_ff;
            rsp_level_ff <= MLEVEL_W'(n_ff);
            rsp_col_ff   <= pcol_ff;
            rsp_row_ff   <= prow_ff;
            rsp_last_ff  <= !produce;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.mip_pixel   = rsp_pixel_ff;
   assign rsp.mip_level   = rsp_level_ff;
   assign rsp.col         = rsp_col_ff;
   assign rsp.row         = rsp_row_ff;
   assign rsp.last_of_run = rsp_last_ff;

   // Check sequencer and datapath invariants
   `MBP_ASSERT(a_read_then_avg, clock, reset, mem_re |=> (state_ff == S_AVG), "read not followed by average")
   `MBP_ASSERT(a_idle_no_pend, clock, reset, (state_ff == S_IDLE) |-> !pend_ff, "pending result dropped")
   `MBP_ASSERT(a_level_range, clock, reset, rsp_valid_ff |-> ((rsp_level_ff != '0) && (LEVEL_W'(rsp_level_ff) < levels)), "result level out of range")
   `MBP_ASSERT_NR(a_port_excl, clock, reset || !(mem_we && mem_re), "line buffer read and write together")
endmodule
